// File: hw/rtl/dtsq_pkg.sv
// Shared types, field widths and defaults for the decision tree classifier.
`default_nettype none

package dtsq_pkg;

    // Field widths of the item and result beats
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int LABEL_W    = 12;
    localparam int FEAT_W     = 4;
    localparam int QCNT_W     = 3;
    localparam int VAL_W      = 16;
    localparam int SLOT_W     = 4;

    // Number of question fields carried by an item beat
    localparam int IN_QUESTIONS = 5;

    // Default sizes of the node table and the feature vector
    localparam int NODE_SLOTS_DEF    = 1024;
    localparam int MAX_QUESTIONS_DEF = 5;
    localparam int FEATURE_COUNT_DEF = 16;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_NODE    = 2'd0,
        CMD_CLEAR_NODE    = 2'd1,
        CMD_WRITE_FEATURE = 2'd2,
        CMD_CLASSIFY      = 2'd3
    } t_cmd;

    // Control states of the walker
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage : dtsq_pkg

`default_nettype wire

// File: hw/rtl/decision_tree_set_question_classifier.sv
// Top level of the decision tree classifier: node memories and the tree walker.
//
//   Channel  Direction  Handshake                   Beat contents
//   item     in         i_in_valid / o_in_stall     command, node fields, feature fields
//   result   out        o_out_valid / i_out_stall   class label, leaf node, walk error
//
// Node write, node clear and feature write beats are taken in the idle state.
// A classify beat reads the root while idle; the walker then reads the node memory
// and the child presence memory once per tree level visited, down to the leaf of a
// full ten-level tree, before the result register is loaded.
// After reset a clearing pass writes the presence memory, one pair of nodes a cycle,
// with o_in_stall held high.
// A finished result waits in the output register while the next item is taken;
// the walker stalls in its last state only if that register is still full and stalled.
`default_nettype none

module decision_tree_set_question_classifier #(
    parameter int NODE_SLOTS    = dtsq_pkg::NODE_SLOTS_DEF,
    parameter int MAX_QUESTIONS = dtsq_pkg::MAX_QUESTIONS_DEF,
    parameter int FEATURE_COUNT = dtsq_pkg::FEATURE_COUNT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [dtsq_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [dtsq_pkg::IDX_W-1:0]     i_node_index,
    input  wire logic [dtsq_pkg::LABEL_W-1:0]   i_node_class,
    input  wire logic [dtsq_pkg::FEAT_W-1:0]    i_node_feature,
    input  wire logic [dtsq_pkg::QCNT_W-1:0]    i_question_count,
    input  wire logic [dtsq_pkg::VAL_W-1:0]     i_question_0,
    input  wire logic [dtsq_pkg::VAL_W-1:0]     i_question_1,
    input  wire logic [dtsq_pkg::VAL_W-1:0]     i_question_2,
    input  wire logic [dtsq_pkg::VAL_W-1:0]     i_question_3,
    input  wire logic [dtsq_pkg::VAL_W-1:0]     i_question_4,
    input  wire logic [dtsq_pkg::SLOT_W-1:0]    i_feature_slot,
    input  wire logic [dtsq_pkg::VAL_W-1:0]     i_feature_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [dtsq_pkg::LABEL_W-1:0]        o_class_label,
    output logic [dtsq_pkg::IDX_W-1:0]          o_leaf_node,
    output logic                                o_walk_error
);

    localparam int NW     = $clog2(NODE_SLOTS);
    localparam int PAIRS  = (NODE_SLOTS + 1) / 2;
    localparam int PW     = $clog2(PAIRS);
    localparam int QCW    = $clog2(MAX_QUESTIONS + 1);
    localparam int QV_W   = MAX_QUESTIONS * dtsq_pkg::VAL_W;
    localparam int FEAT_OFF = dtsq_pkg::LABEL_W;
    localparam int CNT_OFF  = FEAT_OFF + dtsq_pkg::FEAT_W;
    localparam int Q_OFF    = CNT_OFF + QCW;
    localparam int NODE_W   = Q_OFF + QV_W;

    // Memories: node contents by node number, child presence by parent number
    logic [NODE_W-1:0] r_node_mem [NODE_SLOTS];
    logic [1:0]        r_pair_mem [PAIRS];
    logic [NODE_W-1:0] r_node_q;
    logic [1:0]        r_pair_q;

    // Control and walk registers
    dtsq_pkg::t_state             r_state, n_state;
    logic [PW-1:0]                r_clr_addr, n_clr_addr;
    logic                         r_root_present, n_root_present;
    logic [NW-1:0]                r_node, n_node;
    logic [dtsq_pkg::LABEL_W-1:0] r_res_label, n_res_label;
    logic [NW-1:0]                r_res_leaf, n_res_leaf;
    logic                         r_res_err, n_res_err;
    logic                         r_out_valid, n_out_valid;
    logic [dtsq_pkg::LABEL_W-1:0] r_out_label;
    logic [NW-1:0]                r_out_leaf;
    logic                         r_out_err;
    logic                         out_load;

    // Item decode
    dtsq_pkg::t_cmd               cmd;
    logic                         in_accept;
    logic [16:0]                  idx_ext;
    logic                         idx_ok;
    logic [3:0]                   cnt_ext;
    logic [QCW-1:0]               cnt_sat;
    logic [QV_W-1:0]              q_word;
    logic [NODE_W-1:0]            node_wd;
    logic                         node_we;
    logic                         pres_we;
    logic                         pres_wd;
    logic                         fv_we;

    // Walk datapath
    logic [NW:0]                  left_idx;
    logic [NW:0]                  right_idx;
    logic                         left_p;
    logic                         right_p;
    logic                         match;
    logic [NW:0]                  next_idx;
    logic                         next_p;
    logic [NW:0]                  rd_idx;
    logic [16:0]                  leaf_ext;

    logic [dtsq_pkg::VAL_W-1:0]   q_in [dtsq_pkg::IN_QUESTIONS];

    assign cmd       = dtsq_pkg::t_cmd'(i_cmd);
    assign o_in_stall = (r_state != dtsq_pkg::ST_IDLE);
    assign in_accept = i_in_valid && !o_in_stall;

    assign idx_ext = {7'b0, i_node_index};
    assign idx_ok  = idx_ext < 17'(NODE_SLOTS);

    // Question count saturates to the number of question slots in a node.
    assign cnt_ext = {1'b0, i_question_count};
    assign cnt_sat = (cnt_ext > 4'(MAX_QUESTIONS)) ? QCW'(MAX_QUESTIONS) : QCW'(cnt_ext);

    assign q_in[0] = i_question_0;
    assign q_in[1] = i_question_1;
    assign q_in[2] = i_question_2;
    assign q_in[3] = i_question_3;
    assign q_in[4] = i_question_4;

    // Question slots without an item field are written as zero.
    for (genvar q = 0; q < MAX_QUESTIONS; q++) begin : g_qword
        if (q < dtsq_pkg::IN_QUESTIONS) begin : g_from_item
            assign q_word[q*dtsq_pkg::VAL_W +: dtsq_pkg::VAL_W] = q_in[q];
        end else begin : g_zero
            assign q_word[q*dtsq_pkg::VAL_W +: dtsq_pkg::VAL_W] = '0;
        end
    end

    assign node_wd = {q_word, cnt_sat, i_node_feature, i_node_class};

    // Write strobes of the item beat
    always_comb begin
        node_we = 1'b0;
        pres_we = 1'b0;
        pres_wd = 1'b0;
        fv_we   = 1'b0;
        if (in_accept) begin
            unique case (cmd)
                dtsq_pkg::CMD_WRITE_NODE: begin
                    node_we = idx_ok;
                    pres_we = idx_ok;
                    pres_wd = 1'b1;
                end
                dtsq_pkg::CMD_CLEAR_NODE: begin
                    pres_we = idx_ok;
                end
                dtsq_pkg::CMD_WRITE_FEATURE: begin
                    fv_we = 1'b1;
                end
                dtsq_pkg::CMD_CLASSIFY: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Node memory: one write port from the item, one read port for the walker.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[idx_ext[NW-1:0]] <= node_wd;
        end
        r_node_q <= r_node_mem[rd_idx[NW-1:0]];
    end

    // Presence memory: entry p holds the present bits of nodes 2p and 2p+1.
    always_ff @(posedge i_clk) begin
        if (r_state == dtsq_pkg::ST_CLEAR) begin
            r_pair_mem[r_clr_addr] <= 2'b00;
        end else if (pres_we) begin
            r_pair_mem[idx_ext[PW:1]][idx_ext[0]] <= pres_wd;
        end
        r_pair_q <= r_pair_mem[rd_idx[PW-1:0]];
    end

    // Question match of the node just read
    dtsq_match #(
        .MAX_QUESTIONS (MAX_QUESTIONS),
        .FEATURE_COUNT (FEATURE_COUNT),
        .QCW           (QCW)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fv_we     (fv_we),
        .i_fv_slot   (i_feature_slot),
        .i_fv_value  (i_feature_value),
        .i_feat      (r_node_q[FEAT_OFF +: dtsq_pkg::FEAT_W]),
        .i_count     (r_node_q[CNT_OFF +: QCW]),
        .i_questions (r_node_q[Q_OFF +: QV_W]),
        .o_match     (match)
    );

    // Children of the current node; a child beyond the table is absent.
    assign left_idx  = {r_node, 1'b0};
    assign right_idx = {r_node, 1'b1};
    assign left_p    = r_pair_q[0] && (left_idx < (NW+1)'(NODE_SLOTS));
    assign right_p   = r_pair_q[1] && (right_idx < (NW+1)'(NODE_SLOTS));
    assign next_idx  = match ? left_idx : right_idx;
    assign next_p    = match ? left_p : right_p;

    // The walker reads the root when idle and the chosen child while walking.
    assign rd_idx = (r_state == dtsq_pkg::ST_IDLE) ? (NW+1)'(1) : next_idx;

    assign out_load = !r_out_valid || !i_out_stall;

    // Next state and walk decisions
    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_root_present = r_root_present;
        n_node         = r_node;
        n_res_label    = r_res_label;
        n_res_leaf     = r_res_leaf;
        n_res_err      = r_res_err;
        n_out_valid    = r_out_valid && i_out_stall;
        unique case (r_state)
            dtsq_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + PW'(1);
                if (r_clr_addr == PW'(PAIRS - 1)) begin
                    n_state = dtsq_pkg::ST_IDLE;
                end
            end
            dtsq_pkg::ST_IDLE: begin
                if (pres_we && (idx_ext == 17'd1)) begin
                    n_root_present = pres_wd;
                end
                if (in_accept && (cmd == dtsq_pkg::CMD_CLASSIFY)) begin
                    n_node = NW'(1);
                    if (r_root_present) begin
                        n_state = dtsq_pkg::ST_WALK;
                    end else begin
                        n_res_label = '0;
                        n_res_leaf  = '0;
                        n_res_err   = 1'b1;
                        n_state     = dtsq_pkg::ST_DONE;
                    end
                end
            end
            dtsq_pkg::ST_WALK: begin
                if (!left_p && !right_p) begin
                    n_res_label = r_node_q[dtsq_pkg::LABEL_W-1:0];
                    n_res_leaf  = r_node;
                    n_res_err   = 1'b0;
                    n_state     = dtsq_pkg::ST_DONE;
                end else if (!next_p) begin
                    n_res_label = r_node_q[dtsq_pkg::LABEL_W-1:0];
                    n_res_leaf  = r_node;
                    n_res_err   = 1'b1;
                    n_state     = dtsq_pkg::ST_DONE;
                end else begin
                    n_node = next_idx[NW-1:0];
                end
            end
            dtsq_pkg::ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = dtsq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dtsq_pkg::ST_CLEAR;
            r_clr_addr     <= '0;
            r_root_present <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_root_present <= n_root_present;
            r_out_valid    <= n_out_valid;
        end
    end

    // Walk and result payload registers
    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_res_label <= n_res_label;
        r_res_leaf  <= n_res_leaf;
        r_res_err   <= n_res_err;
        if ((r_state == dtsq_pkg::ST_DONE) && out_load) begin
            r_out_label <= r_res_label;
            r_out_leaf  <= r_res_leaf;
            r_out_err   <= r_res_err;
        end
    end

    // The reported leaf number keeps its low ten bits.
    assign leaf_ext      = 17'(r_out_leaf);
    assign o_out_valid   = r_out_valid;
    assign o_class_label = r_out_label;
    assign o_leaf_node   = leaf_ext[dtsq_pkg::IDX_W-1:0];
    assign o_walk_error  = r_out_err;

    // The walker never stands on node zero.
    a_walk_node_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtsq_pkg::ST_WALK) |-> (r_node != '0))
        else $error("walker stands on node zero");

    // A classify with an absent root goes straight to the result.
    a_absent_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (cmd == dtsq_pkg::CMD_CLASSIFY) && !r_root_present)
        |=> ((r_state == dtsq_pkg::ST_DONE) && r_res_err && (r_res_leaf == '0)))
        else $error("absent root not reported as an error");

    // A new result is not loaded while the output register is full and stalled.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dtsq_pkg::ST_DONE) && r_out_valid && i_out_stall)
        |=> ((r_state == dtsq_pkg::ST_DONE) && $stable(r_out_label)))
        else $error("result overwritten while the output is stalled");

    // No result appears during the clearing pass.
    a_clear_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtsq_pkg::ST_CLEAR) |-> !o_out_valid)
        else $error("result during the clearing pass");

endmodule : decision_tree_set_question_classifier

`default_nettype wire

// File: hw/rtl/dtsq_match.sv
// Feature vector registers and the question match of one tree node.
`default_nettype none

module dtsq_match #(
    parameter int MAX_QUESTIONS = dtsq_pkg::MAX_QUESTIONS_DEF,
    parameter int FEATURE_COUNT = dtsq_pkg::FEATURE_COUNT_DEF,
    parameter int QCW           = $clog2(MAX_QUESTIONS + 1)
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_fv_we,
    input  wire logic [dtsq_pkg::SLOT_W-1:0]             i_fv_slot,
    input  wire logic [dtsq_pkg::VAL_W-1:0]              i_fv_value,
    input  wire logic [dtsq_pkg::FEAT_W-1:0]             i_feat,
    input  wire logic [QCW-1:0]                          i_count,
    input  wire logic [MAX_QUESTIONS*dtsq_pkg::VAL_W-1:0] i_questions,
    output logic                                         o_match
);

    localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    logic [dtsq_pkg::VAL_W-1:0] r_fv [FEATURE_COUNT];
    logic [7:0]                 slot_ext;
    logic [7:0]                 feat_ext;
    logic                       slot_ok;
    logic                       feat_ok;
    logic [dtsq_pkg::VAL_W-1:0] sel_value;

    assign slot_ext = {4'b0, i_fv_slot};
    assign feat_ext = {4'b0, i_feat};
    assign slot_ok  = slot_ext < 8'(FEATURE_COUNT);
    assign feat_ok  = feat_ext < 8'(FEATURE_COUNT);

    // Feature vector: cleared at reset, one slot written per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FEATURE_COUNT; f++) begin
                r_fv[f] <= '0;
            end
        end else if (i_fv_we && slot_ok) begin
            r_fv[slot_ext[FW-1:0]] <= i_fv_value;
        end
    end

    // A tested feature beyond the vector compares as zero.
    assign sel_value = feat_ok ? r_fv[feat_ext[FW-1:0]] : '0;

    // Any valid question value equal to the feature sends the walk left.
    always_comb begin
        o_match = 1'b0;
        for (int q = 0; q < MAX_QUESTIONS; q++) begin
            if ((QCW'(q) < i_count) &&
                (i_questions[q*dtsq_pkg::VAL_W +: dtsq_pkg::VAL_W] == sel_value)) begin
                o_match = 1'b1;
            end
        end
    end

endmodule : dtsq_match

`default_nettype wire

// File: verif/tb_decision_tree_set_question_classifier.sv
// Testbench for the decision tree classifier: random beats checked against a tree predictor.
`timescale 1ns / 1ps

module tb_decision_tree_set_question_classifier;

    localparam int IDX_W        = dtsq_pkg::IDX_W;
    localparam int LABEL_W      = dtsq_pkg::LABEL_W;
    localparam int FEAT_W       = dtsq_pkg::FEAT_W;
    localparam int QCNT_W       = dtsq_pkg::QCNT_W;
    localparam int VAL_W        = dtsq_pkg::VAL_W;
    localparam int SLOT_W       = dtsq_pkg::SLOT_W;
    localparam int IN_QUESTIONS = dtsq_pkg::IN_QUESTIONS;
    localparam int NODES        = dtsq_pkg::NODE_SLOTS_DEF;
    localparam int MAX_Q        = dtsq_pkg::MAX_QUESTIONS_DEF;
    localparam int FEATS        = dtsq_pkg::FEATURE_COUNT_DEF;
    localparam int TOTAL_BEATS  = 1400;
    localparam int QUIET_BEATS  = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 2000;

    // One item beat, with the question values gathered into one packed array.
    typedef struct packed {
        dtsq_pkg::t_cmd                     cmd;
        logic [IDX_W-1:0]                   node_index;
        logic [LABEL_W-1:0]                 node_class;
        logic [FEAT_W-1:0]                  node_feature;
        logic [QCNT_W-1:0]                  question_count;
        logic [IN_QUESTIONS-1:0][VAL_W-1:0] question;
        logic [SLOT_W-1:0]                  feature_slot;
        logic [VAL_W-1:0]                   feature_value;
    } t_tree_beat;

    // One result beat.
    typedef struct packed {
        logic [LABEL_W-1:0] class_label;
        logic [IDX_W-1:0]   leaf_node;
        logic               walk_error;
    } t_verdict;

    // Shadow of the node table and feature vector, and the verdicts still owed.
    class t_tree_scoreboard;
        bit                 live [NODES];
        logic [LABEL_W-1:0] lbl [NODES];
        logic [FEAT_W-1:0]  tfeat [NODES];
        int unsigned        qcnt [NODES];
        logic [VAL_W-1:0]   qval [NODES][MAX_Q];
        logic [VAL_W-1:0]   fvec [FEATS];
        t_verdict           awaited [$];
        int                 faults;

        function new();
            foreach (live[i]) live[i] = 1'b0;
            foreach (fvec[i]) fvec[i] = '0;
            faults = 0;
        endfunction

        function bit is_live(int unsigned n);
            return n < NODES && live[n];
        endfunction

        // A node sends the walk left when its tested feature equals any valid question.
        function bit takes_left(int unsigned n);
            logic [VAL_W-1:0] probe;
            probe = (tfeat[n] < FEATS) ? fvec[tfeat[n]] : '0;
            for (int unsigned q = 0; q < qcnt[n]; q++) begin
                if (qval[n][q] == probe) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Walk from the root until a node with no live child, or a missing chosen child.
        function t_verdict walk_tree();
            t_verdict    v;
            int unsigned n;
            int unsigned nxt;
            bit          stop;
            v = '0;
            if (!is_live(1)) begin
                v.walk_error = 1'b1;
                return v;
            end
            n = 1;
            stop = 1'b0;
            while (!stop) begin
                if (!is_live(2 * n) && !is_live(2 * n + 1)) begin
                    stop = 1'b1;
                end else begin
                    nxt = takes_left(n) ? 2 * n : 2 * n + 1;
                    if (!is_live(nxt)) begin
                        v.walk_error = 1'b1;
                        stop = 1'b1;
                    end else begin
                        n = nxt;
                    end
                end
            end
            v.class_label = lbl[n];
            v.leaf_node   = IDX_W'(n);
            return v;
        endfunction

        function void note_item(t_tree_beat b);
            int unsigned n;
            n = b.node_index;
            case (b.cmd)
                dtsq_pkg::CMD_WRITE_NODE: begin
                    lbl[n]   = b.node_class;
                    tfeat[n] = b.node_feature;
                    qcnt[n]  = (b.question_count > MAX_Q) ? MAX_Q : b.question_count;
                    for (int q = 0; q < MAX_Q; q++) qval[n][q] = b.question[q];
                    live[n]  = 1'b1;
                end
                dtsq_pkg::CMD_CLEAR_NODE: begin
                    live[n] = 1'b0;
                end
                dtsq_pkg::CMD_WRITE_FEATURE: begin
                    fvec[b.feature_slot] = b.feature_value;
                end
                dtsq_pkg::CMD_CLASSIFY: begin
                    awaited.insert(awaited.size(), walk_tree());
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_verdict got);
            t_verdict want;
            if (awaited.size() == 0) begin
                $error("result beat with no classify waiting: label %0d leaf %0d error %0b",
                       got.class_label, got.leaf_node, got.walk_error);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (got.class_label !== want.class_label) begin
                $error("class_label: expected %0d, actual %0d", want.class_label, got.class_label);
                faults++;
            end
            if (got.leaf_node !== want.leaf_node) begin
                $error("leaf_node: expected %0d, actual %0d", want.leaf_node, got.leaf_node);
                faults++;
            end
            if (got.walk_error !== want.walk_error) begin
                $error("walk_error: expected %0b, actual %0b", want.walk_error, got.walk_error);
                faults++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                i_out_stall;
    t_tree_beat          beat;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [LABEL_W-1:0]  o_class_label;
    logic [IDX_W-1:0]    o_leaf_node;
    logic                o_walk_error;

    t_tree_scoreboard    sb;
    logic [VAL_W-1:0]    steer_fvec [FEATS];
    int                  beats_sent = 0;
    bit                  quiet = 1'b0;
    bit                  hold_request = 1'b0;
    bit                  holding = 1'b0;

    always #1 i_clk = ~i_clk;

    decision_tree_set_question_classifier uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (beat.cmd),
        .i_node_index     (beat.node_index),
        .i_node_class     (beat.node_class),
        .i_node_feature   (beat.node_feature),
        .i_question_count (beat.question_count),
        .i_question_0     (beat.question[0]),
        .i_question_1     (beat.question[1]),
        .i_question_2     (beat.question[2]),
        .i_question_3     (beat.question[3]),
        .i_question_4     (beat.question[4]),
        .i_feature_slot   (beat.feature_slot),
        .i_feature_value  (beat.feature_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_class_label    (o_class_label),
        .o_leaf_node      (o_leaf_node),
        .o_walk_error     (o_walk_error)
    );

    // Mostly small values so that questions often hit, sometimes any 16-bit value.
    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return VAL_W'($urandom_range(0, 7));
        return VAL_W'($urandom);
    endfunction

    // A random node number at the given tree depth.
    function automatic int unsigned heap_pick(int unsigned depth);
        return (1 << depth) | $urandom_range(0, (1 << depth) - 1);
    endfunction

    function automatic t_tree_beat random_beat();
        t_tree_beat b;
        b.cmd            = dtsq_pkg::t_cmd'($urandom_range(0, 3));
        b.node_index     = IDX_W'($urandom_range(0, NODES - 1));
        b.node_class     = LABEL_W'($urandom);
        b.node_feature   = FEAT_W'($urandom);
        b.question_count = QCNT_W'($urandom);
        for (int q = 0; q < IN_QUESTIONS; q++) b.question[q] = pick_value();
        b.feature_slot   = SLOT_W'($urandom);
        b.feature_value  = pick_value();
        return b;
    endfunction

    function automatic t_tree_beat node_cmd(int unsigned idx, int unsigned cls,
                                            int unsigned feat, int unsigned cnt,
                                            logic [IN_QUESTIONS-1:0][VAL_W-1:0] qs);
        t_tree_beat b;
        b = random_beat();
        b.cmd            = dtsq_pkg::CMD_WRITE_NODE;
        b.node_index     = IDX_W'(idx);
        b.node_class     = LABEL_W'(cls);
        b.node_feature   = FEAT_W'(feat);
        b.question_count = QCNT_W'(cnt);
        b.question       = qs;
        return b;
    endfunction

    function automatic t_tree_beat feature_cmd(int unsigned slot, logic [VAL_W-1:0] value);
        t_tree_beat b;
        b = random_beat();
        b.cmd           = dtsq_pkg::CMD_WRITE_FEATURE;
        b.feature_slot  = SLOT_W'(slot);
        b.feature_value = value;
        return b;
    endfunction

    function automatic t_tree_beat bare_cmd(dtsq_pkg::t_cmd c, int unsigned idx);
        t_tree_beat b;
        b = random_beat();
        b.cmd        = c;
        b.node_index = IDX_W'(idx);
        return b;
    endfunction

    // A node write with random contents, tests leaning towards the first few features.
    function automatic t_tree_beat node_beat(int unsigned idx);
        logic [IN_QUESTIONS-1:0][VAL_W-1:0] qs;
        int unsigned                        feat;
        for (int q = 0; q < IN_QUESTIONS; q++) qs[q] = pick_value();
        feat = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, FEATS - 1);
        return node_cmd(idx, $urandom_range(0, 4095), feat, $urandom_range(0, 7), qs);
    endfunction

    // Offer one beat and hold it until accepted, then perhaps leave a gap.
    task automatic send_beat(input t_tree_beat b);
        int gap;
        if (b.cmd == dtsq_pkg::CMD_WRITE_FEATURE) steer_fvec[b.feature_slot] = b.feature_value;
        beat       <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        if (!quiet && !holding && !hold_request && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write every node on the path to a random target, mostly steering the walk along it
    // with the current feature vector, and sometimes the sibling at each level as well.
    task automatic plant_path(input int unsigned depth);
        int unsigned      target;
        int unsigned      node;
        int unsigned      child;
        int unsigned      cnt;
        int unsigned      pos;
        logic [VAL_W-1:0] probe;
        t_tree_beat       b;
        target = heap_pick(depth);
        for (int unsigned k = 0; k <= depth; k++) begin
            node = target >> (depth - k);
            b = node_beat(node);
            if (k < depth && $urandom_range(0, 3) != 0) begin
                child = target >> (depth - k - 1);
                probe = steer_fvec[b.node_feature];
                for (int q = 0; q < IN_QUESTIONS; q++) begin
                    if (b.question[q] == probe) b.question[q] = probe + 1'b1;
                end
                if (child % 2 == 0) begin
                    if (b.question_count == 0) b.question_count = QCNT_W'($urandom_range(1, 7));
                    cnt = (b.question_count > MAX_Q) ? MAX_Q : b.question_count;
                    pos = $urandom_range(0, cnt - 1);
                    b.question[pos] = probe;
                end
            end
            send_beat(b);
            if (k > 0 && $urandom_range(0, 1) == 0) send_beat(node_beat(node ^ 1));
        end
    endtask

    // Result sink: one long hold-off on request, otherwise short random stalls.
    initial begin : result_sink
        int span;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                holding = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_request = 1'b0;
                holding = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                span = $urandom_range(1, 7);
                i_out_stall <= 1'b1;
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // Both channels are observed at the same edge; results first, then the new item.
    always @(posedge i_clk) begin : beat_monitor
        t_verdict got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.class_label = o_class_label;
                got.leaf_node   = o_leaf_node;
                got.walk_error  = o_walk_error;
                sb.check_result(got);
            end
            if (i_in_valid && !o_in_stall) sb.note_item(beat);
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) dead_cycles = 0;
            else dead_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int unsigned roll;
        sb = new();
        foreach (steer_fvec[i]) steer_fvec[i] = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        beat       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tree, saturated question count, single leaf, both turns,
        // missing chosen child, cleared root, and a right-hand chain to the last node.
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));
        send_beat(feature_cmd(15, 16'hFFFF));
        send_beat(feature_cmd(0, 16'h0000));
        send_beat(node_cmd(1, 12'hFFF, 15, 7, {16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0}));
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));
        send_beat(node_cmd(2, 12'h000, 0, 0, '0));
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));
        send_beat(feature_cmd(15, 16'h1234));
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));
        send_beat(node_cmd(3, 12'hABC, 0, 6, {16'd5, 16'd4, 16'd3, 16'd2, 16'd1}));
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));
        send_beat(bare_cmd(dtsq_pkg::CMD_CLEAR_NODE, 1));
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));
        send_beat(node_cmd(0, 12'h555, 15, 5, '1));
        send_beat(node_cmd(1, 12'h001, 15, 0, '1));
        for (int unsigned k = 7; k < NODES; k = 2 * k + 1) begin
            send_beat(node_cmd(k, $urandom_range(0, 4095), 0, 0, '1));
        end
        send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, 0));

        // Random: mostly tree building, feature writes and classifies, with clears and raw noise.
        hold_request = 1'b1;
        while (beats_sent < TOTAL_BEATS) begin
            quiet = (beats_sent >= TOTAL_BEATS - QUIET_BEATS);
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                plant_path($urandom_range(0, 9));
            end else if (roll < 52) begin
                send_beat(feature_cmd($urandom_range(0, FEATS - 1), pick_value()));
            end else if (roll < 85) begin
                send_beat(bare_cmd(dtsq_pkg::CMD_CLASSIFY, $urandom_range(0, NODES - 1)));
            end else if (roll < 93) begin
                send_beat(bare_cmd(dtsq_pkg::CMD_CLEAR_NODE, heap_pick($urandom_range(0, 9))));
            end else begin
                send_beat(random_beat());
            end
        end
        i_in_valid <= 1'b0;

        // Drain the outstanding verdicts, then watch for strays.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dtsq_pkg.sv
hw/rtl/dtsq_match.sv
hw/rtl/decision_tree_set_question_classifier.sv
verif/tb_decision_tree_set_question_classifier.sv
